// ----- hw/rtl/spct_pkg.sv -----
// ----------------------------------------------------------------------------
// Shape pair collision test package
// Test kind codes, default coordinate width and multiplier count.
// ----------------------------------------------------------------------------
package spct_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int NUM_MUL         = 6;

    typedef enum logic [1:0] {
        FUNC_BOX     = 2'd0,
        FUNC_CIRCLE  = 2'd1,
        FUNC_SEGMENT = 2'd2
    } func_t;

endpackage

// ----- hw/rtl/spct_smul.sv -----
// ----------------------------------------------------------------------------
// Registered signed multiplier
// One signed product per cycle, loaded when the enable is high.
// ----------------------------------------------------------------------------
module spct_smul #(
    parameter int A_WIDTH = spct_pkg::COORD_WIDTH_DEF + 1
) (
    input  logic                         aclk,
    input  logic                         en,
    input  logic signed [A_WIDTH-1:0]    a,
    input  logic signed [A_WIDTH-1:0]    b,
    output logic signed [2*A_WIDTH-1:0]  p
);

    logic signed [2*A_WIDTH-1:0] p_reg;
    logic signed [2*A_WIDTH-1:0] p_next;

    assign p_next = (2*A_WIDTH)'(a) * (2*A_WIDTH)'(b);

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

// ----- hw/rtl/shape_pair_collision_test_core.sv -----
// ----------------------------------------------------------------------------
// Shape pair collision test core
// Box-box, circle-circle and segment-segment overlap test on signed
// fixed-point coordinates, one pair per cycle while s_tready is high.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: s_tuser carries the test kind, s_tdata the eight
//   coordinates of shapes A and B. One item is taken per cycle when
//   s_tvalid and s_tready are high.
//   Result channel m_*: m_tdata bit 0 is the collision flag, one result per
//   input item, in order.
//   Each item passes four register stages in order (differences, products
//   in six multipliers, sums, final compare) before m_tvalid rises. The
//   stages take one item per cycle while the receiver does not stall.
//   Reset clears all stage valid bits; nothing else is held.
//   When the receiver stalls, the stages fill one by one; s_tready drops
//   only when every stage holds an item, and nothing is lost or repeated.
// ----------------------------------------------------------------------------
module shape_pair_collision_test_core #(
    parameter int COORD_WIDTH = spct_pkg::COORD_WIDTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // a_p0, a_p1, a_p2, a_p3, b_p0, b_p1, b_p2, b_p3
    input  logic [8*COORD_WIDTH-1:0] s_tdata,
    // func
    input  logic [1:0]               s_tuser,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // colliding, zero padded
    output logic [7:0]               m_tdata
);

    import spct_pkg::*;

    localparam int W = COORD_WIDTH;
    localparam int D = W + 1;
    localparam int P = 2 * D;
    localparam int S = P + 1;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    logic [1:0] func1_reg, func2_reg, func3_reg;
    logic       box1_reg, box2_reg, box3_reg;
    logic       spos1_reg, spos2_reg, spos3_reg;

    logic signed [D-1:0] op_a_reg [NUM_MUL];
    logic signed [D-1:0] op_b_reg [NUM_MUL];
    logic signed [D-1:0] op_a_next [NUM_MUL];
    logic signed [D-1:0] op_b_next [NUM_MUL];
    logic signed [P-1:0] prod [NUM_MUL];

    logic signed [S-1:0] r0_reg, r1_reg, r2_reg;
    logic signed [S-1:0] r0_next, r1_next, r2_next;

    logic [7:0] m_tdata_reg;
    logic [7:0] m_tdata_next;

    logic signed [W-1:0] crd [8];
    logic signed [D-1:0] s1x, s1y, s2x, s2y, dx, dy, rsum;
    logic                box_next, spos_next;
    logic                sn_ok, tn_ok, seg_hit, hit;

    // ready chain, last stage first
    assign rdy4     = !v4_reg || m_tready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_tvalid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (rdy4) begin
                v4_reg <= v3_reg;
            end
        end
    end

    // stage 1: differences, box compare, multiplier operands
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            crd[i] = $signed(s_tdata[i*W +: W]);
        end
        s1x  = D'(crd[2]) - D'(crd[0]);
        s1y  = D'(crd[3]) - D'(crd[1]);
        s2x  = D'(crd[6]) - D'(crd[4]);
        s2y  = D'(crd[7]) - D'(crd[5]);
        dx   = D'(crd[0]) - D'(crd[4]);
        dy   = D'(crd[1]) - D'(crd[5]);
        rsum = D'(crd[2]) + D'(crd[6]);

        box_next  = !((crd[3] < crd[5]) || (crd[1] > crd[7]) ||
                      (crd[0] > crd[6]) || (crd[2] < crd[4]));
        spos_next = rsum > 0;

        for (int i = 0; i < NUM_MUL; i++) begin
            op_a_next[i] = '0;
            op_b_next[i] = '0;
        end
        if (s_tuser == FUNC_CIRCLE) begin
            op_a_next[0] = dx;
            op_b_next[0] = dx;
            op_a_next[1] = dy;
            op_b_next[1] = dy;
            op_a_next[2] = rsum;
            op_b_next[2] = rsum;
        end else begin
            op_a_next[0] = s1x;
            op_b_next[0] = s2y;
            op_a_next[1] = s2x;
            op_b_next[1] = s1y;
            op_a_next[2] = s1x;
            op_b_next[2] = dy;
            op_a_next[3] = s1y;
            op_b_next[3] = dx;
            op_a_next[4] = s2x;
            op_b_next[4] = dy;
            op_a_next[5] = s2y;
            op_b_next[5] = dx;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            func1_reg <= s_tuser;
            box1_reg  <= box_next;
            spos1_reg <= spos_next;
            for (int i = 0; i < NUM_MUL; i++) begin
                op_a_reg[i] <= op_a_next[i];
                op_b_reg[i] <= op_b_next[i];
            end
        end
    end

    // stage 2: products
    for (genvar g = 0; g < NUM_MUL; g++) begin : g_mul
        spct_smul #(
            .A_WIDTH (D)
        ) u_mul (
            .aclk (aclk),
            .en   (rdy2),
            .a    (op_a_reg[g]),
            .b    (op_b_reg[g]),
            .p    (prod[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            func2_reg <= func1_reg;
            box2_reg  <= box1_reg;
            spos2_reg <= spos1_reg;
        end
    end

    // stage 3: circle distance and radius terms, or den, sn, tn
    always_comb begin
        if (func2_reg == FUNC_CIRCLE) begin
            r0_next = S'(prod[0]) + S'(prod[1]);
        end else begin
            r0_next = S'(prod[0]) - S'(prod[1]);
        end
        r1_next = S'(prod[2]) - S'(prod[3]);
        r2_next = S'(prod[4]) - S'(prod[5]);
    end

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            func3_reg <= func2_reg;
            box3_reg  <= box2_reg;
            spos3_reg <= spos2_reg;
            r0_reg    <= r0_next;
            r1_reg    <= r1_next;
            r2_reg    <= r2_next;
        end
    end

    // stage 4: sign and magnitude checks, result select
    always_comb begin
        if (r0_reg[S-1]) begin
            sn_ok = (r1_reg <= 0) && (r1_reg >= r0_reg);
            tn_ok = (r2_reg <= 0) && (r2_reg >= r0_reg);
        end else begin
            sn_ok = (r1_reg >= 0) && (r1_reg <= r0_reg);
            tn_ok = (r2_reg >= 0) && (r2_reg <= r0_reg);
        end
        seg_hit = (r0_reg != '0) && sn_ok && tn_ok;

        case (func3_reg)
            FUNC_BOX:     hit = box3_reg;
            FUNC_CIRCLE:  hit = spos3_reg && (r0_reg < r1_reg);
            FUNC_SEGMENT: hit = seg_hit;
            default:      hit = 1'b0;
        endcase
        m_tdata_next = {7'd0, hit};
    end

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = m_tdata_reg;

    // unused test kind never reports a hit
    assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && rdy4 && func3_reg != FUNC_BOX && func3_reg != FUNC_CIRCLE &&
         func3_reg != FUNC_SEGMENT) |=> !m_tdata[0])
        else $error("hit reported for unused test kind");

    // circles with a nonpositive radius sum never collide
    assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && rdy4 && func3_reg == FUNC_CIRCLE && !spos3_reg) |=> !m_tdata[0])
        else $error("hit reported for nonpositive radius sum");

    // parallel segments never collide
    assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && rdy4 && func3_reg == FUNC_SEGMENT && r0_reg == '0) |=> !m_tdata[0])
        else $error("hit reported for parallel segments");

    // input stalls only when every stage is full
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (v1_reg && v2_reg && v3_reg && v4_reg && !m_tready))
        else $error("input stalled with a free stage");

    // a stage holding an item that cannot move keeps it
    assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && !rdy4) |=> v3_reg && $stable(r0_reg) && $stable(func3_reg))
        else $error("stage 3 item lost under stall");

endmodule

// ----- bench/tb_shape_pair_collision_test_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Shape pair collision test core testbench
// Drives box, circle and segment pair tests through the input stream and
// checks each collision flag against a predictor. The predictor uses exact
// 64-bit integer arithmetic. Covers directed corner cases, random shaped and
// raw items, a back-to-back stretch, and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_shape_pair_collision_test_core;
    import spct_pkg::*;

    localparam int CW            = COORD_WIDTH_DEF;
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int MAX_PRINTS    = 50;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    logic              aclk;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [8*CW-1:0]   s_tdata  = '0;
    logic [1:0]        s_tuser  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [7:0]        m_tdata;

    logic              hit_queue[$];
    logic              exp_hit;
    int                err_count   = 0;
    int                quiet_cycles = 0;
    int                hold_len    = 0;
    bit                idle_en     = 1'b1;

    shape_pair_collision_test_core #(.COORD_WIDTH(CW)) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic logic calc_collision(input logic [1:0] fn,
                                            input logic [8*CW-1:0] data);
        longint a[4];
        longint b[4];
        longint dx, dy, rsum, s1x, s1y, s2x, s2y, den, sn, tn;
        for (int i = 0; i < 4; i++) begin
            a[i] = longint'($signed(data[i*CW +: CW]));
            b[i] = longint'($signed(data[(i+4)*CW +: CW]));
        end
        dx = a[0] - b[0];
        dy = a[1] - b[1];
        case (fn)
            FUNC_BOX: begin
                if (a[3] < b[1] || a[1] > b[3] || a[0] > b[2] || a[2] < b[0])
                    return 1'b0;
                return 1'b1;
            end
            FUNC_CIRCLE: begin
                rsum = a[2] + b[2];
                if (rsum <= 0)
                    return 1'b0;
                return (dx*dx + dy*dy) < rsum*rsum;
            end
            FUNC_SEGMENT: begin
                s1x = a[2] - a[0];
                s1y = a[3] - a[1];
                s2x = b[2] - b[0];
                s2y = b[3] - b[1];
                den = s1x*s2y - s2x*s1y;
                sn  = s1x*dy - s1y*dx;
                tn  = s2x*dy - s2y*dx;
                if (den == 0)
                    return 1'b0;
                if (den < 0) begin
                    den = -den;
                    sn  = -sn;
                    tn  = -tn;
                end
                if (sn < 0 || tn < 0 || sn > den || tn > den)
                    return 1'b0;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        if (err_count < MAX_PRINTS)
            $display("%0t: MISMATCH: %s", $realtime, msg);
        err_count++;
    endtask

    // retire results, then record the item taken at this edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (hit_queue.size() == 0) begin
                    report_mismatch($sformatf("result 0x%02h with none expected", m_tdata));
                end else begin
                    exp_hit = hit_queue.pop_front();
                    if (m_tdata !== {7'b0, exp_hit})
                        report_mismatch($sformatf("colliding: got 0x%02h, expected 0x%02h",
                                                  m_tdata, {7'b0, exp_hit}));
                end
            end
            if (s_tvalid && s_tready)
                hit_queue.push_back(calc_collision(s_tuser, s_tdata));
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (hold_len > 0) begin
                m_tready <= 1'b0;
                repeat (hold_len) @(posedge aclk);
                hold_len = 0;
            end
            m_tready <= !idle_en || ($urandom_range(99) >= 32);
        end
    end

    task automatic send_item(input logic [1:0] fn, input logic [8*CW-1:0] data);
        while (idle_en && $urandom_range(99) < 32) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= fn;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_pair(input logic [1:0] fn,
                             input int a0, input int a1, input int a2, input int a3,
                             input int b0, input int b1, input int b2, input int b3);
        send_item(fn, {CW'(b3), CW'(b2), CW'(b1), CW'(b0),
                       CW'(a3), CW'(a2), CW'(a1), CW'(a0)});
    endtask

    function automatic int rand_near(input int span);
        return int'($urandom_range(2*span)) - span;
    endfunction

    task automatic send_random_item();
        int x0, y0, x1, y1, u0, v0, u1, v1, tmp;
        logic [1:0] fn;
        if ($urandom_range(99) < 25) begin
            send_item(2'($urandom_range(3)),
                      {$urandom(), $urandom(), $urandom(), $urandom()});
            return;
        end
        fn = 2'($urandom_range(2));
        case (fn)
            FUNC_BOX: begin
                x0 = rand_near(1024);
                y0 = rand_near(1024);
                x1 = x0 + int'($urandom_range(768));
                y1 = y0 + int'($urandom_range(768));
                u0 = rand_near(1024);
                v0 = rand_near(1024);
                u1 = u0 + int'($urandom_range(768));
                v1 = v0 + int'($urandom_range(768));
                if ($urandom_range(9) == 0) begin
                    tmp = x0; x0 = x1; x1 = tmp;
                end
                if ($urandom_range(9) == 0) begin
                    tmp = v0; v0 = v1; v1 = tmp;
                end
                // share an edge now and then
                if ($urandom_range(7) == 0)
                    u0 = x1;
                send_pair(fn, x0, y0, x1, y1, u0, v0, u1, v1);
            end
            FUNC_CIRCLE: begin
                x0 = rand_near(512);
                y0 = rand_near(512);
                u0 = rand_near(512);
                v0 = rand_near(512);
                x1 = int'($urandom_range(400));
                u1 = ($urandom_range(9) == 0) ? rand_near(400) : int'($urandom_range(400));
                send_pair(fn, x0, y0, x1, int'($urandom_range(65535)),
                          u0, v0, u1, int'($urandom_range(65535)));
            end
            default: begin
                x0 = rand_near(512);
                y0 = rand_near(512);
                x1 = rand_near(512);
                y1 = rand_near(512);
                case ($urandom_range(9))
                    0, 1: begin
                        // parallel or collinear copy
                        tmp = ($urandom_range(1) == 0) ? 0 : rand_near(64);
                        u0 = x0 + tmp;
                        v0 = y0 + tmp;
                        u1 = x1 + tmp;
                        v1 = y1 + tmp;
                    end
                    2: begin
                        u0 = x1;
                        v0 = y1;
                        u1 = rand_near(512);
                        v1 = rand_near(512);
                    end
                    default: begin
                        u0 = rand_near(512);
                        v0 = rand_near(512);
                        u1 = rand_near(512);
                        v1 = rand_near(512);
                    end
                endcase
                send_pair(fn, x0, y0, x1, y1, u0, v0, u1, v1);
            end
        endcase
    endtask

    task automatic test_directed();
        send_pair(FUNC_BOX, 0, 0, 16, 16, 16, 16, 32, 32);
        send_pair(FUNC_BOX, 0, 0, 16, 16, 17, 0, 32, 16);
        send_pair(FUNC_BOX, 0, 0, 16, 16, 0, 17, 16, 32);
        send_pair(FUNC_BOX, 16, 16, 0, 0, 0, 0, 16, 16);
        send_pair(FUNC_BOX, -32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767);
        send_pair(FUNC_BOX, 32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768);
        send_pair(FUNC_CIRCLE, 0, 0, 16, 0, 32, 0, 16, 0);
        send_pair(FUNC_CIRCLE, 0, 0, 16, 12345, 31, 0, 16, -1);
        send_pair(FUNC_CIRCLE, 0, 0, -5, 0, 0, 0, 3, 0);
        send_pair(FUNC_CIRCLE, 0, 0, 0, 0, 0, 0, 0, 0);
        send_pair(FUNC_CIRCLE, -32768, -32768, 32767, 0, 32767, 32767, 32767, 0);
        send_pair(FUNC_CIRCLE, 0, 0, 32767, -32768, 0, 0, 32767, 32767);
        send_pair(FUNC_CIRCLE, 0, 0, -32768, 0, 0, 0, -32768, 0);
        send_pair(FUNC_SEGMENT, 0, 0, 32, 32, 0, 32, 32, 0);
        send_pair(FUNC_SEGMENT, 0, 0, 32, 0, 0, 16, 32, 16);
        send_pair(FUNC_SEGMENT, 0, 0, 32, 0, 16, 0, 48, 0);
        send_pair(FUNC_SEGMENT, 0, 0, 16, 16, 16, 16, 32, 0);
        send_pair(FUNC_SEGMENT, 0, 0, 32, 0, 16, 0, 16, 32);
        send_pair(FUNC_SEGMENT, 0, 0, 16, 0, 32, -16, 32, 16);
        send_pair(FUNC_SEGMENT, -32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
        send_pair(FUNC_SEGMENT, 5, 5, 5, 5, 0, 0, 10, 10);
        send_pair(FUNC_UNUSED, 0, 0, 16, 16, 0, 0, 16, 16);
        send_item(FUNC_UNUSED, '1);
        send_item(FUNC_BOX, '1);
    endtask

    task automatic test_random_mix(input int count);
        repeat (count) send_random_item();
    endtask

    task automatic test_back_to_back(input int count);
        idle_en = 1'b0;
        repeat (count) send_random_item();
        idle_en = 1'b1;
    endtask

    // hold the receiver while items keep coming, so the pipe fills up
    task automatic test_receiver_hold(input int count);
        hold_len = HOLD_CYCLES;
        repeat (count) send_random_item();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_mix(500);
        test_back_to_back(200);
        test_receiver_hold(150);
        test_random_mix(430);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (hit_queue.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
